// ===== rtl/nwt_pkg.sv =====
// shared types and constants for the number to word tokens block
package nwt_pkg;

  localparam int unsigned NumW       = 31;
  localparam int unsigned WordW      = 5;
  localparam int unsigned NumDigits  = 10;
  localparam int unsigned BinW       = 32;
  localparam int unsigned BitsPerStep = 4;
  localparam int unsigned ConvSteps  = BinW / BitsPerStep;
  localparam int unsigned QueueDepth = 2;

  localparam logic [WordW-1:0] WORD_ZERO     = 5'd0;
  localparam logic [WordW-1:0] WORD_TEN_BASE = 5'd10;
  localparam logic [WordW-1:0] WORD_TENS_OFS = 5'd18;
  localparam logic [WordW-1:0] WORD_HUNDRED  = 5'd28;
  localparam logic [WordW-1:0] WORD_THOUSAND = 5'd29;
  localparam logic [WordW-1:0] WORD_MILLION  = 5'd30;
  localparam logic [WordW-1:0] WORD_BILLION  = 5'd31;

  // bcd digits, index 9 is the most significant
  typedef logic [NumDigits-1:0][3:0] nwt_digits_t;

endpackage

// ===== rtl/number_to_word_tokens_top.sv =====
// top level of the number to word tokens block
//
// input channel: in_valid_i / in_stall_o with number_value_i (31 bits);
//   a transfer happens on a rising edge with valid high and stall low
// output channel: out_valid_o / out_stall_i with word_code_o and last_word_o;
//   one word per transfer, last_word_o marks the final word of a number
// front: binary to bcd conversion, four bits per cycle, then a push state that
//   hands the digits to a two-entry queue
// back: walks a 21-slot word mask of the queued digits, one word per cycle
//   unless stalled, into an output register; each number is loaded first
// the front converts the next number while the back is still emitting
// receiver stall: the output register holds its word; the back stops, the
//   queue fills and the front then raises in_stall_o
// reset: asynchronous active low; clears all control state, queue empty,
//   no word pending, ready for a transfer right after release
module number_to_word_tokens_top (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [nwt_pkg::NumW-1:0]    number_value_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [nwt_pkg::WordW-1:0]   word_code_o,
  output logic                        last_word_o
);
  import nwt_pkg::*;

  // front to queue
  logic        push;
  logic        full;
  nwt_digits_t push_digits;

  // queue to back
  logic        q_valid;
  logic        q_pop;
  nwt_digits_t q_digits;

  nwt_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .number_value_i (number_value_i),
    .push_o         (push),
    .digits_o       (push_digits),
    .full_i         (full)
  );

  nwt_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_digits),
    .full_o  (full),
    .valid_o (q_valid),
    .data_o  (q_digits),
    .pop_i   (q_pop)
  );

  // back end drives the output register directly
  nwt_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_data_i    (q_digits),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .word_code_o (word_code_o),
    .last_word_o (last_word_o)
  );

endmodule

// ===== rtl/nwt_front.sv =====
// front end: accepts numbers and converts them to decimal digits
module nwt_front (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [nwt_pkg::NumW-1:0]     number_value_i,
  output logic                         push_o,
  output nwt_pkg::nwt_digits_t         digits_o,
  input  logic                         full_i
);
  import nwt_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CONV = 2'd1;
  localparam logic [1:0] ST_PUSH = 2'd2;

  localparam int unsigned CntW = $clog2(ConvSteps);

  logic [1:0]      state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [BinW-1:0] bin_q, bin_d;
  nwt_digits_t     bcd_q, bcd_d;
  logic            accept;

  // shift-add-3 over one nibble of binary input, msb first
  function automatic nwt_digits_t dabble_nibble(nwt_digits_t bcd,
                                                 logic [BitsPerStep-1:0] bits);
    logic [NumDigits*4-1:0] flat;
    nwt_digits_t            b;
    flat = bcd;
    for (int i = BitsPerStep - 1; i >= 0; i--) begin
      for (int d = 0; d < NumDigits; d++) begin
        if (flat[d*4 +: 4] >= 4'd5) flat[d*4 +: 4] = flat[d*4 +: 4] + 4'd3;
      end
      flat = {flat[NumDigits*4-2:0], bits[i]};
    end
    b = flat;
    return b;
  endfunction

  assign in_stall_o = !((state_q == ST_IDLE) || ((state_q == ST_PUSH) && !full_i));
  assign accept     = in_valid_i && !in_stall_o;
  assign push_o     = (state_q == ST_PUSH) && !full_i;
  assign digits_o   = bcd_q;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    bin_d   = bin_q;
    bcd_d   = bcd_q;
    unique case (state_q)
      ST_IDLE: ;
      ST_CONV: begin
        bcd_d = dabble_nibble(bcd_q, bin_q[BinW-1 -: BitsPerStep]);
        bin_d = bin_q << BitsPerStep;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CntW'(ConvSteps - 1)) state_d = ST_PUSH;
      end
      ST_PUSH: begin
        if (push_o) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
    if (accept) begin
      state_d = ST_CONV;
      cnt_d   = '0;
      bin_d   = BinW'(number_value_i);
      bcd_d   = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bin_q <= bin_d;
    bcd_q <= bcd_d;
  end

endmodule

// ===== rtl/nwt_queue.sv =====
// two-entry queue of digit sets between front and back
module nwt_queue (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  nwt_pkg::nwt_digits_t data_i,
  output logic                 full_o,
  output logic                 valid_o,
  output nwt_pkg::nwt_digits_t data_o,
  input  logic                 pop_i
);
  import nwt_pkg::*;

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  nwt_digits_t     mem_q [QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(QueueDepth));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  function automatic logic [PtrW-1:0] ptr_inc(logic [PtrW-1:0] p);
    return (p == PtrW'(QueueDepth - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) wr_ptr_q <= ptr_inc(wr_ptr_q);
      if (do_pop)  rd_ptr_q <= ptr_inc(rd_ptr_q);
      if (do_push && !do_pop)      cnt_q <= cnt_q + 1'b1;
      else if (do_pop && !do_push) cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= data_i;
  end

endmodule

// ===== rtl/nwt_back.sv =====
// back end: walks the word slots of one number and emits one word per cycle unless stalled
module nwt_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        q_valid_i,
  input  nwt_pkg::nwt_digits_t        q_data_i,
  output logic                        q_pop_o,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [nwt_pkg::WordW-1:0]   word_code_o,
  output logic                        last_word_o
);
  import nwt_pkg::*;

  // five slots per group (digit, hundred, tens/teen/unit, unit, scale) plus zero
  localparam int unsigned NumGroups = 4;
  localparam int unsigned SlotsPerG = 5;
  localparam int unsigned NumSlots  = NumGroups * SlotsPerG + 1;

  typedef struct packed {
    logic [NumSlots-1:0]            valid;
    logic [NumSlots-1:0][WordW-1:0] code;
  } nwt_slots_t;

  function automatic nwt_slots_t build_slots(nwt_digits_t dg);
    nwt_slots_t       s;
    logic [3:0]       h, t, u;
    logic             nz;
    logic [WordW-1:0] scale;
    int               b;
    s = '0;
    for (int g = 0; g < NumGroups; g++) begin
      b = g * SlotsPerG;
      if (g == 0) begin
        h = 4'd0;
        t = 4'd0;
        u = dg[9];
      end else begin
        h = dg[11 - 3*g];
        t = dg[10 - 3*g];
        u = dg[9 - 3*g];
      end
      case (g)
        0:       scale = WORD_BILLION;
        1:       scale = WORD_MILLION;
        default: scale = WORD_THOUSAND;
      endcase
      nz = (h != 4'd0) || (t != 4'd0) || (u != 4'd0);
      s.valid[b]     = (h != 4'd0);
      s.code[b]      = {1'b0, h};
      s.valid[b + 1] = (h != 4'd0);
      s.code[b + 1]  = WORD_HUNDRED;
      s.valid[b + 2] = (t != 4'd0) || (u != 4'd0);
      if (t >= 4'd2)      s.code[b + 2] = WORD_TENS_OFS + {1'b0, t};
      else if (t == 4'd1) s.code[b + 2] = WORD_TEN_BASE + {1'b0, u};
      else                s.code[b + 2] = {1'b0, u};
      s.valid[b + 3] = (t >= 4'd2) && (u != 4'd0);
      s.code[b + 3]  = {1'b0, u};
      s.valid[b + 4] = nz && (g < NumGroups - 1);
      s.code[b + 4]  = scale;
    end
    s.valid[NumSlots-1] = (dg == '0);
    s.code[NumSlots-1]  = WORD_ZERO;
    return s;
  endfunction

  nwt_digits_t         digits_q;
  logic [NumSlots-1:0] mask_q, mask_d;
  logic                busy_q, busy_d;
  logic                out_valid_q, out_valid_d;
  logic [WordW-1:0]    word_q, word_d;
  logic                last_q, last_d;
  logic                adv, load;
  nwt_slots_t          cur_slots, new_slots;
  logic [NumSlots-1:0] pick, remain;
  logic [WordW-1:0]    pick_code;

  assign cur_slots = build_slots(digits_q);
  assign new_slots = build_slots(q_data_i);

  // lowest pending slot goes next
  assign pick   = mask_q & (~mask_q + 1'b1);
  assign remain = mask_q & ~pick;

  always_comb begin
    pick_code = '0;
    for (int i = 0; i < NumSlots; i++) begin
      if (pick[i]) pick_code = pick_code | cur_slots.code[i];
    end
  end

  assign adv     = !out_valid_q || !out_stall_i;
  assign load    = !busy_q && q_valid_i;
  assign q_pop_o = load;

  always_comb begin
    out_valid_d = out_valid_q;
    word_d      = word_q;
    last_d      = last_q;
    mask_d      = mask_q;
    busy_d      = busy_q;
    if (adv) begin
      out_valid_d = busy_q;
      if (busy_q) begin
        word_d = pick_code;
        last_d = (remain == '0);
        mask_d = remain;
        busy_d = (remain != '0);
      end
    end
    if (load) begin
      mask_d = new_slots.valid;
      busy_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mask_q <= mask_d;
    word_q <= word_d;
    last_q <= last_d;
    if (load) digits_q <= q_data_i;
  end

  assign out_valid_o = out_valid_q;
  assign word_code_o = word_q;
  assign last_word_o = last_q;

endmodule
